### rtl/core/prac_pkg.sv
// Package for the protected region access check core.
// Holds field widths, stream packing offsets, request and status codes and
// the token type passed along the region cell chain. No dependencies.
package prac_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int PAGE_BITS   = 12;
    localparam int ADDR_W      = 48;

    localparam int REQ_W    = 2;
    localparam int BASE_W   = 48;
    localparam int LEN_W    = 48;
    localparam int SLOT_W   = 4;
    localparam int PFN_W    = 36;
    localparam int STATUS_W = 2;

    localparam int REQ_LSB  = 0;
    localparam int BASE_LSB = REQ_LSB + REQ_W;
    localparam int LEN_LSB  = BASE_LSB + BASE_W;
    localparam int SLOT_LSB = LEN_LSB + LEN_W;
    localparam int PFN_LSB  = SLOT_LSB + SLOT_W;
    localparam int IN_BITS  = PFN_LSB + PFN_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_BITS    = SLOT_W + STATUS_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [ADDR_W:0]   t_end;
    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_CHECK  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NOSLOT = 2'd2
    } t_status;

    // Request token handed from cell to cell. For an add, start and stop hold
    // the new region; for a check they hold the access range.
    typedef struct packed {
        logic  vld;
        t_req  req;
        t_addr start;
        t_end  stop;
        t_slot pos;
        t_slot rem;
        logic  gone;
        logic  hit;
        t_slot given;
    } t_tok;

    typedef struct packed {
        t_slot   given;
        t_status status;
        logic    allowed;
    } t_res;

endpackage

### rtl/core/prac_cell.sv
// One region slot of the protected region access check chain.
// Holds the slot's valid mark, base and end, and updates the passing token.
// Depends on prac_pkg.
module prac_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  prac_pkg::t_tok i_tok,
    output prac_pkg::t_tok o_tok
);
    import prac_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_addr r_base;
    t_end  r_end;
    logic  w_store;
    t_tok  r_tok;
    t_tok  n_tok;

    always_comb begin
        n_valid = r_valid;
        w_store = 1'b0;
        n_tok = i_tok;
        n_tok.pos = i_tok.pos + t_slot'(1);
        n_tok.rem = i_tok.rem - t_slot'(1);
        if (i_tok.vld) begin
            case (i_tok.req)
                REQ_ADD: begin
                    if (!r_valid && !i_tok.hit) begin
                        n_valid = 1'b1;
                        w_store = 1'b1;
                        n_tok.hit = 1'b1;
                        n_tok.given = i_tok.pos;
                    end
                end
                REQ_REMOVE: begin
                    if (!i_tok.gone && i_tok.rem == '0) begin
                        n_tok.gone = 1'b1;
                        if (r_valid) begin
                            n_valid = 1'b0;
                            n_tok.hit = 1'b1;
                        end
                    end
                end
                REQ_CHECK: begin
                    if (r_valid && !(i_tok.stop <= {1'b0, r_base} ||
                                     {1'b0, i_tok.start} >= r_end)) begin
                        n_tok.hit = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_base <= i_tok.start;
            r_end  <= i_tok.stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

### rtl/core/protected_region_access_check_core.sv
// Each request is registered at the chain head, then passes every region cell's
// token register in order; the result is registered at the output.
// One request at a time: the next input transfer is taken only after the token
// has walked the chain of region cells one slot per cycle, and no result is held.
// Reset clears every slot's valid mark at once; no clearing pass is needed.
// Top level of the protected region access check; depends on prac_pkg, prac_cell.
module protected_region_access_check_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // Fields from bit 0: req_type, region_base, length, slot_index, page_frame.
    input  logic [prac_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // Fields from bit 0: given_slot, status, access_allowed.
    output logic [prac_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import prac_pkg::*;

    logic  w_in_take;
    logic  w_out_take;
    t_addr w_base;
    t_addr w_len;
    t_addr w_start;
    logic [PFN_W+PAGE_BITS-1:0] w_pfn_addr;
    t_tok  n_tok0;
    t_tok  r_tok0;
    t_tok  w_tok [MAX_REGIONS+1];
    logic [MAX_REGIONS:0] w_vld_vec;
    t_tok  w_tail;
    t_res  w_res;
    logic  r_busy;
    logic  n_busy;
    logic  r_out_vld;
    logic  n_out_vld;
    t_res  r_out;
    t_res  n_out;
    logic  r_hold_vld;
    logic  n_hold_vld;
    t_res  r_hold;
    t_res  n_hold;

    assign o_s_axis_tready = !r_busy && !r_hold_vld;
    assign w_in_take  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_take = r_out_vld && i_m_axis_tready;

    assign w_pfn_addr = {i_s_axis_tdata[PFN_LSB +: PFN_W], {PAGE_BITS{1'b0}}};
    assign w_start = t_addr'(w_pfn_addr);
    assign w_base  = t_addr'(i_s_axis_tdata[BASE_LSB +: BASE_W]);
    assign w_len   = t_addr'(i_s_axis_tdata[LEN_LSB +: LEN_W]);

    always_comb begin
        n_tok0.vld   = w_in_take;
        n_tok0.req   = t_req'(i_s_axis_tdata[REQ_LSB +: REQ_W]);
        n_tok0.start = (n_tok0.req == REQ_ADD) ? w_base : w_start;
        n_tok0.stop  = {1'b0, n_tok0.start} + {1'b0, w_len};
        n_tok0.pos   = '0;
        n_tok0.rem   = i_s_axis_tdata[SLOT_LSB +: SLOT_W];
        n_tok0.gone  = 1'b0;
        n_tok0.hit   = 1'b0;
        n_tok0.given = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0.vld <= 1'b0;
        end else begin
            r_tok0 <= n_tok0;
        end
    end

    assign w_tok[0] = r_tok0;

    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
        prac_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    for (genvar g = 0; g <= MAX_REGIONS; g++) begin : g_vld
        assign w_vld_vec[g] = w_tok[g].vld;
    end

    assign w_tail = w_tok[MAX_REGIONS];

    always_comb begin
        w_res.given   = '0;
        w_res.status  = ST_OK;
        w_res.allowed = 1'b0;
        case (w_tail.req)
            REQ_ADD: begin
                if (w_tail.hit) begin
                    w_res.given = w_tail.given;
                end else begin
                    w_res.status = ST_FULL;
                end
            end
            REQ_REMOVE: begin
                if (!w_tail.hit) begin
                    w_res.status = ST_NOSLOT;
                end
            end
            REQ_CHECK: begin
                w_res.allowed = !w_tail.hit;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_busy     = r_busy;
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_hold_vld = r_hold_vld;
        n_hold     = r_hold;
        if (w_in_take) begin
            n_busy = 1'b1;
        end
        if (w_out_take) begin
            if (r_hold_vld) begin
                n_out      = r_hold;
                n_hold_vld = 1'b0;
            end else begin
                n_out_vld = 1'b0;
            end
        end
        if (w_tail.vld) begin
            n_busy = 1'b0;
            if (n_out_vld) begin
                n_hold     = w_res;
                n_hold_vld = 1'b1;
            end else begin
                n_out     = w_res;
                n_out_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_out_vld  <= 1'b0;
            r_hold_vld <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_out_vld  <= n_out_vld;
            r_hold_vld <= n_hold_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_hold <= n_hold;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.allowed, r_out.status, r_out.given};

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld_vec))
        else $error("more than one request token in the cell chain");

    a_tail_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.vld |-> r_busy)
        else $error("token left the chain with no request in flight");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> (r_tok0.vld && $countones(w_vld_vec) == 1))
        else $error("accepted request did not enter the chain alone");

    a_hold_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_vld |-> r_out_vld)
        else $error("held result without a pending output");

endmodule
